// ===== hdl/upsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Upscaler package
// Display geometry, field widths, register indexes and the types shared by
// the controller and the datapath of the pixel upscaler.
// ----------------------------------------------------------------------------
package upsc_pkg;

  // Display the image is centred on.
  localparam int unsigned DisplayWidth  = 320;
  localparam int unsigned DisplayHeight = 240;

  // Field widths.
  localparam int unsigned PixW   = 16;
  localparam int unsigned AddrW  = 20;
  localparam int unsigned CoordW = 10;
  localparam int unsigned SizeW  = 10;
  localparam int unsigned SpanW  = 12;  // size times factor, up to 3 * 1023
  localparam int unsigned FactW  = 2;
  localparam int unsigned ProdW  = 2 * SpanW;
  localparam int unsigned TdataW = PixW + AddrW + 2 * CoordW;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdxWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxEnable = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StEmit
  } upsc_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic latch;  // take the input word and start a pixel
    logic setup;  // form the base buffer address
    logic emit;   // load the next copy into the output register
  } upsc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic last_copy;  // the copy about to be emitted is the pixel's final one
  } upsc_status_t;

endpackage

// ===== hdl/nearest_neighbor_pixel_upscaler_core.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor pixel upscaler
// Replicates each RGB565 source pixel 1, 4 or 9 times with buffer address
// and centered screen coordinates.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order, one word per pixel. The factor f is 2
// when the source is exactly half the display, else 3 when three times the
// source fits, else 1 (and always 1 with upscaling disabled). Each pixel gives
// f*f output words, row by row within its block. A pixel holds the block while
// its word is taken, its base address is multiplied out, and the single copy
// sequencer emits one copy per cycle while the output register has room. The
// last copy waits in the output register while the next pixel is taken. The
// user must write configuration between pixels only; it is not enforced.
module nearest_neighbor_pixel_upscaler_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port: 0 source width, 1 source height, 2 enable.
  input  logic                         cfg_we_i,
  input  logic [upsc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [upsc_pkg::SizeW-1:0]   cfg_data_i,
  // Source pixels.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [upsc_pkg::PixW-1:0]    s_axis_tdata,   // [15:0] pixel
  // Output copies.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [15:0] pixel_out, [35:16] buffer_address, [45:36] screen_x, [55:46] screen_y
  output logic [upsc_pkg::TdataW-1:0]  m_axis_tdata,
  output logic                         m_axis_tlast,   // last_of_run
  output logic                         m_axis_tuser    // [0] end_of_frame
);
  import upsc_pkg::*;

  upsc_cmd_t    cmd;
  upsc_status_t status;

  upsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  upsc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_eof_o   (m_axis_tuser)
  );

endmodule

// ===== hdl/upsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Upscaler controller
// Sequences one source pixel at a time: accept, address setup, then one
// copy per cycle while the output register has room.
// ----------------------------------------------------------------------------
module upsc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  upsc_pkg::upsc_status_t status_i,
  output upsc_pkg::upsc_cmd_t    cmd_o
);
  import upsc_pkg::*;

  upsc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (status_i.out_free && status_i.last_copy) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.latch = 1'b0;
    cmd_o.setup = 1'b0;
    cmd_o.emit  = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
      end
      StEmit: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/upsc_datapath.sv =====
// ----------------------------------------------------------------------------
// Upscaler datapath
// Configuration registers, source position counters, factor and centering
// logic, the copy address generator and the output register.
// ----------------------------------------------------------------------------
module upsc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [upsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [upsc_pkg::SizeW-1:0]    cfg_data_i,
  input  logic [upsc_pkg::PixW-1:0]     pixel_i,
  input  upsc_pkg::upsc_cmd_t           cmd_i,
  output upsc_pkg::upsc_status_t        status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [upsc_pkg::TdataW-1:0]   out_data_o,
  output logic                          out_last_o,
  output logic                          out_eof_o
);
  import upsc_pkg::*;

  // Configuration.
  logic [SizeW-1:0] width_q, height_q;
  logic             enable_q;

  // Source position.
  logic [SizeW-1:0] col_q, row_q;

  // Per-pixel working registers.
  logic [PixW-1:0]   pix_q;
  logic [FactW-1:0]  fact_q;
  logic [SpanW-1:0]  stride_q;
  logic [CoordW-1:0] xoff_q, yoff_q;
  logic [SpanW-1:0]  col_base_q, row_base_q;
  logic              eof_q;
  logic [FactW-1:0]  dx_q, dy_q;
  logic [AddrW-1:0]  addr_q;

  // Output register.
  logic              out_valid_q;
  logic [PixW-1:0]   out_pix_q;
  logic [AddrW-1:0]  out_addr_q;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic              out_last_q, out_eof_q;

  logic [SpanW-1:0]  w2_c, w3_c, h2_c, h3_c;
  logic [FactW-1:0]  fact_c;
  logic [SpanW-1:0]  span_w_c, span_h_c;
  logic [SpanW-1:0]  col_base_c, row_base_c;
  logic [CoordW-1:0] xoff_c, yoff_c;
  logic              last_col_c, last_row_c;
  logic [ProdW-1:0]  prod_c;
  logic [FactW-1:0]  fmax_c;
  logic              last_dx_c, last_copy_c;
  logic              out_free_c;

  assign w2_c = {1'b0, width_q, 1'b0};
  assign h2_c = {1'b0, height_q, 1'b0};
  assign w3_c = {2'b00, width_q} + w2_c;
  assign h3_c = {2'b00, height_q} + h2_c;

  always_comb begin
    if (!enable_q) begin
      fact_c = 2'd1;
    end else if (w2_c == SpanW'(DisplayWidth) && h2_c == SpanW'(DisplayHeight)) begin
      fact_c = 2'd2;
    end else if (w3_c <= SpanW'(DisplayWidth) && h3_c <= SpanW'(DisplayHeight)) begin
      fact_c = 2'd3;
    end else begin
      fact_c = 2'd1;
    end
  end

  // Multiplications by the factor are shift-and-add selections.
  always_comb begin
    case (fact_c)
      2'd2: begin
        span_w_c   = w2_c;
        span_h_c   = h2_c;
        col_base_c = {1'b0, col_q, 1'b0};
        row_base_c = {1'b0, row_q, 1'b0};
      end
      2'd3: begin
        span_w_c   = w3_c;
        span_h_c   = h3_c;
        col_base_c = {2'b00, col_q} + {1'b0, col_q, 1'b0};
        row_base_c = {2'b00, row_q} + {1'b0, row_q, 1'b0};
      end
      default: begin
        span_w_c   = {2'b00, width_q};
        span_h_c   = {2'b00, height_q};
        col_base_c = {2'b00, col_q};
        row_base_c = {2'b00, row_q};
      end
    endcase
  end

  assign xoff_c = (span_w_c < SpanW'(DisplayWidth))
                ? CoordW'((SpanW'(DisplayWidth) - span_w_c) >> 1) : '0;
  assign yoff_c = (span_h_c < SpanW'(DisplayHeight))
                ? CoordW'((SpanW'(DisplayHeight) - span_h_c) >> 1) : '0;

  assign last_col_c = ({1'b0, col_q} + 11'd1) >= {1'b0, width_q};
  assign last_row_c = ({1'b0, row_q} + 11'd1) >= {1'b0, height_q};

  assign prod_c = row_base_q * stride_q;

  assign fmax_c      = fact_q - 2'd1;
  assign last_dx_c   = (dx_q == fmax_c);
  assign last_copy_c = last_dx_c && (dy_q == fmax_c);
  assign out_free_c  = !out_valid_q || out_ready_i;

  assign status_o.out_free  = out_free_c;
  assign status_o.last_copy = last_copy_c;

  // Configuration and position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeW'(160);
      height_q <= SizeW'(120);
      enable_q <= 1'b1;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgIdxWidth:  width_q  <= cfg_data_i;
          CfgIdxHeight: height_q <= cfg_data_i;
          CfgIdxEnable: enable_q <= cfg_data_i[0];
          default:      width_q  <= width_q;
        endcase
      end
      if (cmd_i.latch) begin
        if (last_col_c) begin
          col_q <= '0;
          row_q <= last_row_c ? '0 : row_q + SizeW'(1);
        end else begin
          col_q <= col_q + SizeW'(1);
        end
      end
    end
  end

  // Per-pixel state and copy sequencing.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      pix_q      <= pixel_i;
      fact_q     <= fact_c;
      stride_q   <= span_w_c;
      xoff_q     <= xoff_c;
      yoff_q     <= yoff_c;
      col_base_q <= col_base_c;
      row_base_q <= row_base_c;
      eof_q      <= last_col_c && last_row_c;
      dx_q       <= '0;
      dy_q       <= '0;
    end
    if (cmd_i.setup) begin
      addr_q <= prod_c[AddrW-1:0] + AddrW'(col_base_q);
    end
    if (cmd_i.emit) begin
      if (last_dx_c) begin
        // Next block row: back to the left column, one stride down.
        dx_q   <= '0;
        dy_q   <= dy_q + 2'd1;
        addr_q <= addr_q + AddrW'(stride_q) - AddrW'(fmax_c);
      end else begin
        dx_q   <= dx_q + 2'd1;
        addr_q <= addr_q + AddrW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pix_q  <= pix_q;
      out_addr_q <= addr_q;
      out_x_q    <= xoff_q + col_base_q[CoordW-1:0] + CoordW'(dx_q);
      out_y_q    <= yoff_q + row_base_q[CoordW-1:0] + CoordW'(dy_q);
      out_last_q <= last_copy_c;
      out_eof_q  <= last_copy_c && eof_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_y_q, out_x_q, out_addr_q, out_pix_q};
  assign out_last_o  = out_last_q;
  assign out_eof_o   = out_eof_q;

endmodule
